// File: hw/rtl/ospt_pkg.sv
`default_nettype none
package ospt_pkg;

  localparam logic [2:0] KIND_TICK          = 3'd0;
  localparam logic [2:0] KIND_POST_ONE_SHOT = 3'd1;
  localparam logic [2:0] KIND_POST_PERIODIC = 3'd2;
  localparam logic [2:0] KIND_REMOVE        = 3'd3;
  localparam logic [2:0] KIND_CLEAR         = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [4:0] RESULT_CAP = 5'd16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  task_id;
    logic [31:0] context_req;
    logic [31:0] delay;
    logic [31:0] period;
  } in_t;

  typedef struct packed {
    logic        fired;
    logic [7:0]  fired_id;
    logic [31:0] fired_context;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_INSERT, S_DROP, S_TICK, S_FLUSH, S_RESP
  } state_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_PEND, OUT_STATUS, OUT_FINAL
  } out_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       idx_inc;
    logic       set_status;
    logic [1:0] status;
    logic       insert;
    logic       drop;
    logic       clear;
    logic       tick_upd;
    logic       fire_push;
    out_sel_t   out_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       at_end;
    logic       match;
    logic       full;
    logic       fires;
    logic       repeating;
    logic       out_free;
    logic       pend_valid;
    logic       cap_reached;
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/ospt_ctrl.sv
`default_nettype none
module ospt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [2:0]     in_kind,
  output      logic           in_stall,
  input  wire ospt_pkg::sts_t sts,
  output      ospt_pkg::cmd_t cmd
);
  import ospt_pkg::*;

  state_t state_r, state_nxt;
  logic   fire_wait;

  assign in_stall  = (state_r != S_IDLE);
  assign fire_wait = sts.fires && sts.pend_valid && !sts.out_free && !sts.cap_reached;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_kind == KIND_TICK) begin
            state_nxt = S_TICK;
          end else if (in_kind == KIND_POST_ONE_SHOT || in_kind == KIND_POST_PERIODIC ||
                       in_kind == KIND_REMOVE) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_FIND: begin
        priority if (sts.at_end) begin
          if (sts.kind == KIND_REMOVE || sts.full) state_nxt = S_RESP;
          else state_nxt = S_INSERT;
        end else if (sts.match) begin
          state_nxt = (sts.kind == KIND_REMOVE) ? S_DROP : S_INSERT;
        end
      end
      S_INSERT: state_nxt = S_RESP;
      S_DROP:   state_nxt = S_RESP;
      S_TICK: begin
        if (sts.at_end) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_sel = OUT_NONE;
    cmd.status  = STATUS_OK;
    unique case (state_r)
      S_IDLE: cmd.load_item = in_valid;
      S_FIND: begin
        priority if (sts.at_end) begin
          cmd.set_status = (sts.kind == KIND_REMOVE) || sts.full;
          cmd.status     = (sts.kind == KIND_REMOVE) ? STATUS_NOT_FOUND : STATUS_FULL;
        end else if (!sts.match) begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_INSERT: cmd.insert = 1'b1;
      S_DROP:   cmd.drop   = 1'b1;
      S_TICK: begin
        if (!sts.at_end) begin
          priority if (!sts.fires) begin
            cmd.tick_upd = 1'b1;
            cmd.idx_inc  = 1'b1;
          end else if (!fire_wait) begin
            cmd.fire_push = 1'b1;
            if (sts.pend_valid && !sts.cap_reached) cmd.out_sel = OUT_PEND;
            if (sts.repeating) begin
              cmd.tick_upd = 1'b1;
              cmd.idx_inc  = 1'b1;
            end else begin
              cmd.drop = 1'b1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) cmd.out_sel = OUT_FINAL;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_sel = OUT_STATUS;
          cmd.clear   = (sts.kind == KIND_CLEAR);
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/ospt_dp.sv
`default_nettype none
module ospt_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ospt_pkg::in_t  in_data,
  input  wire ospt_pkg::cmd_t cmd,
  output      ospt_pkg::sts_t sts,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      ospt_pkg::out_t out_data
);
  import ospt_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS + 1);
  localparam int PW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // entries kept in visiting order, position 0 is the front
  logic [7:0]  id_r  [NUM_SLOTS];
  logic [31:0] ctx_r [NUM_SLOTS];
  logic [31:0] rem_r [NUM_SLOTS];
  logic [31:0] per_r [NUM_SLOTS];
  logic        rep_r [NUM_SLOTS];

  in_t         item_r;
  logic [IW-1:0] count_r, idx_r;
  logic [4:0]  n_r;
  logic [1:0]  status_r;
  logic        pend_v_r;
  logic [7:0]  pend_id_r;
  logic [31:0] pend_ctx_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic [PW-1:0] rd;
  logic [31:0]   rd_rem, tick_val;
  logic          fires, new_entry, new_rep;

  assign rd        = idx_r[PW-1:0];
  assign rd_rem    = rem_r[rd];
  assign fires     = (rd_rem == 32'd0) || (rd_rem == 32'd1);
  assign tick_val  = fires ? per_r[rd] : rd_rem - 32'd1;
  assign new_entry = (idx_r == count_r);
  assign new_rep   = (item_r.kind == KIND_POST_PERIODIC);

  assign sts.kind        = item_r.kind;
  assign sts.at_end      = (idx_r == count_r);
  assign sts.match       = (id_r[rd] == item_r.task_id);
  assign sts.full        = (count_r == IW'(NUM_SLOTS));
  assign sts.fires       = fires;
  assign sts.repeating   = rep_r[rd];
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.pend_valid  = pend_v_r;
  assign sts.cap_reached = (n_r == RESULT_CAP);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (i == 0) begin
          id_r[i]  <= item_r.task_id;
          ctx_r[i] <= item_r.context_req;
          rem_r[i] <= item_r.delay;
          per_r[i] <= new_rep ? item_r.period : 32'd0;
          rep_r[i] <= new_rep;
        end else if (IW'(i) <= idx_r) begin
          id_r[i]  <= id_r[(i > 0) ? i - 1 : 0];
          ctx_r[i] <= ctx_r[(i > 0) ? i - 1 : 0];
          rem_r[i] <= rem_r[(i > 0) ? i - 1 : 0];
          per_r[i] <= per_r[(i > 0) ? i - 1 : 0];
          rep_r[i] <= rep_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.drop) begin
        if (i < NUM_SLOTS - 1 && IW'(i) >= idx_r) begin
          id_r[i]  <= id_r[(i < NUM_SLOTS - 1) ? i + 1 : i];
          ctx_r[i] <= ctx_r[(i < NUM_SLOTS - 1) ? i + 1 : i];
          rem_r[i] <= rem_r[(i < NUM_SLOTS - 1) ? i + 1 : i];
          per_r[i] <= per_r[(i < NUM_SLOTS - 1) ? i + 1 : i];
          rep_r[i] <= rep_r[(i < NUM_SLOTS - 1) ? i + 1 : i];
        end
      end else if (cmd.tick_upd && rd == PW'(i)) begin
        rem_r[i] <= tick_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r   <= in_data;
      status_r <= STATUS_OK;
    end else if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.fire_push && !sts.cap_reached) begin
      pend_id_r  <= id_r[rd];
      pend_ctx_r <= ctx_r[rd];
    end
    unique case (cmd.out_sel)
      OUT_PEND:   out_data_r <= '{1'b1, pend_id_r, pend_ctx_r, STATUS_OK, 1'b0};
      OUT_STATUS: out_data_r <= '{1'b0, 8'd0, 32'd0, status_r, 1'b1};
      OUT_FINAL: begin
        if (pend_v_r) out_data_r <= '{1'b1, pend_id_r, pend_ctx_r, STATUS_OK, 1'b1};
        else          out_data_r <= '{1'b0, 8'd0, 32'd0, STATUS_OK, 1'b1};
      end
      OUT_NONE:   out_data_r <= out_data_r;
      default:    out_data_r <= out_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        idx_r    <= '0;
        n_r      <= '0;
        pend_v_r <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.insert && new_entry) begin
        count_r <= count_r + IW'(1);
      end else if (cmd.drop) begin
        count_r <= count_r - IW'(1);
      end
      if (cmd.fire_push && !sts.cap_reached) begin
        pend_v_r <= 1'b1;
        n_r      <= n_r + 5'd1;
      end else if (cmd.out_sel == OUT_FINAL) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.out_sel != OUT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/one_shot_periodic_timer_table.sv
// Channel  Direction  Ports                         Payload
// input    in         in_valid, in_stall, in_data   ospt_pkg::in_t
// result   out        out_valid, out_stall, out_data ospt_pkg::out_t
//
// One item at a time; a tick walks the entries one per cycle through a single
// read port, plus any wait on out_stall. Post and remove scan for the id one
// entry per cycle. Clear and unused kinds go straight to the response.
// Reset is synchronous; entries need no clearing pass.
// While a result is held by out_stall the walk waits only when a fresh
// transaction must be pushed out.
`default_nettype none
module one_shot_periodic_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire ospt_pkg::in_t  in_data,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      ospt_pkg::out_t out_data
);
  import ospt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ospt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ospt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hw/rtl/ospt_checker.sv
`default_nettype none
module ospt_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire ospt_pkg::out_t out_data,
  input wire logic           out_valid,
  input wire logic           out_stall
);
  import ospt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("input taken while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  a_more_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.fired) else $error("non-final without fire");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |-> !out_data.fired && out_data.last)
    else $error("bad status transaction");

endmodule

bind one_shot_periodic_timer_table ospt_checker u_ospt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  import ospt_pkg::*;

  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #10 clk = ~clk;

  one_shot_periodic_timer_table #(.NUM_SLOTS(SLOTS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // timer table shadow
  logic [7:0]  t_id [SLOTS];
  logic [31:0] t_ctx [SLOTS];
  logic [31:0] t_rem [SLOTS];
  logic [31:0] t_per [SLOTS];
  logic        t_rep [SLOTS];
  int          t_order [SLOTS];
  int          t_count;

  out_t expected_q[$];
  int errors;
  int send_idle_pct, stall_pct;
  bit hold_off;
  int quiet_cycles;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int find_timer(input logic [7:0] id);
    for (int i = 0; i < t_count; i++)
      if (t_id[t_order[i]] == id) return i;
    return -1;
  endfunction

  function automatic void drop_at(input int pos);
    for (int i = pos; i + 1 < t_count; i++) t_order[i] = t_order[i+1];
    t_count--;
  endfunction

  function automatic logic [1:0] arm_timer(input in_t it, input bit rep);
    int pos, slot;
    bit used[SLOTS];
    pos = find_timer(it.task_id);
    if (pos >= 0) begin
      slot = t_order[pos];
      drop_at(pos);
    end else begin
      if (t_count >= SLOTS) return STATUS_FULL;
      foreach (used[i]) used[i] = 0;
      for (int i = 0; i < t_count; i++) used[t_order[i]] = 1;
      slot = 0;
      for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) slot = i;
    end
    t_id[slot] = it.task_id;
    t_ctx[slot] = it.context_req;
    t_rem[slot] = it.delay;
    t_per[slot] = rep ? it.period : 32'd0;
    t_rep[slot] = rep;
    for (int i = t_count; i > 0; i--) t_order[i] = t_order[i-1];
    t_order[0] = slot;
    t_count++;
    return STATUS_OK;
  endfunction

  task automatic predict_timers(input in_t it);
    out_t r;
    int n, i, s, pos;
    r = '0;
    n = 0;
    if (it.kind == KIND_TICK) begin
      i = 0;
      while (i < t_count) begin
        s = t_order[i];
        if (t_rem[s] != 0) t_rem[s]--;
        if (t_rem[s] == 0) begin
          if (n < RESULT_CAP) begin
            r = '0;
            r.fired = 1'b1;
            r.fired_id = t_id[s];
            r.fired_context = t_ctx[s];
            expected_q.push_back(r);
            n++;
          end
          if (t_rep[s]) t_rem[s] = t_per[s];
          else begin
            drop_at(i);
            continue;
          end
        end
        i++;
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        expected_q.push_back(r);
      end else expected_q[$].last = 1'b1;
      return;
    end
    r.last = 1'b1;
    case (it.kind)
      KIND_POST_ONE_SHOT: r.status = arm_timer(it, 0);
      KIND_POST_PERIODIC: r.status = arm_timer(it, 1);
      KIND_REMOVE: begin
        pos = find_timer(it.task_id);
        if (pos >= 0) drop_at(pos);
        else r.status = STATUS_NOT_FOUND;
      end
      KIND_CLEAR: t_count = 0;
      default: ;
    endcase
    expected_q.push_back(r);
  endtask

  task automatic send_item(input in_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timers(it);
    @(negedge clk);
  endtask

  function automatic in_t rand_item();
    in_t it;
    int p;
    it.kind = 3'($urandom_range(4));
    p = $urandom_range(99);
    if (p < 3) it.kind = 3'($urandom_range(7, 5));
    else if (p < 40) it.kind = KIND_TICK;
    it.task_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(23));
    it.context_req = $urandom;
    it.delay = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(6));
    it.period = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(5));
    if (it.kind == KIND_CLEAR && $urandom_range(3) != 0) it.kind = KIND_TICK;
    return it;
  endfunction

  // receiver
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) quiet_cycles <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        out_t e;
        e = expected_q.pop_front();
        if (out_data.fired !== e.fired) report_mismatch("fired");
        if (out_data.fired_id !== e.fired_id)
          report_mismatch($sformatf("fired_id %0d exp %0d", out_data.fired_id, e.fired_id));
        if (out_data.fired_context !== e.fired_context) report_mismatch("fired_context");
        if (out_data.status !== e.status)
          report_mismatch($sformatf("status %0d exp %0d", out_data.status, e.status));
        if (out_data.last !== e.last) report_mismatch("last");
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("** one_shot_periodic_timer_table: FAILED **");
      $finish;
    end
  end

  typedef struct {
    in_t  it;
    bit   known;
    out_t res;
  } stim_row_t;

  function automatic stim_row_t row(input logic [2:0] k, input logic [7:0] id,
                                    input logic [31:0] c, input logic [31:0] d,
                                    input logic [31:0] p, input bit known,
                                    input logic [1:0] st);
    stim_row_t s;
    s.it = '{kind: k, task_id: id, context_req: c, delay: d, period: p};
    s.known = known;
    s.res = '{fired: 1'b0, fired_id: 8'd0, fired_context: 32'd0, status: st, last: 1'b1};
    return s;
  endfunction

  stim_row_t directed[$];
  in_t it;

  initial begin
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(row(KIND_TICK, 0, 0, 0, 0, 1, STATUS_OK));
    directed.push_back(row(KIND_REMOVE, 8'hFF, 0, 0, 0, 1, STATUS_NOT_FOUND));
    directed.push_back(row(KIND_POST_ONE_SHOT, 8'hFF, '1, 0, '1, 1, STATUS_OK));
    directed.push_back(row(KIND_POST_PERIODIC, 8'h00, 32'h0, 32'h1, 0, 1, STATUS_OK));
    directed.push_back(row(KIND_TICK, 0, 0, 0, 0, 0, STATUS_OK));
    directed.push_back(row(KIND_TICK, 0, 0, 0, 0, 0, STATUS_OK));
    directed.push_back(row(KIND_POST_ONE_SHOT, 8'h00, 32'hA5A5_5A5A, '1, '1, 1, STATUS_OK));
    directed.push_back(row(KIND_POST_PERIODIC, 8'h80, 32'h1234_5678, 2, '1, 1, STATUS_OK));
    directed.push_back(row(KIND_TICK, 0, 0, 0, 0, 0, STATUS_OK));
    directed.push_back(row(KIND_REMOVE, 8'h80, 0, 0, 0, 1, STATUS_OK));
    directed.push_back(row(3'd5, 8'h55, '1, '1, '1, 1, STATUS_OK));
    directed.push_back(row(3'd7, 8'hAA, 0, 0, 0, 1, STATUS_OK));
    directed.push_back(row(KIND_CLEAR, 0, 0, 0, 0, 1, STATUS_OK));
    for (int i = 0; i < 17; i++)
      directed.push_back(row(KIND_POST_PERIODIC, 8'(i + 1), 32'(i), 0, 0, 0,
                             STATUS_OK));
    directed.push_back(row(KIND_POST_ONE_SHOT, 8'h05, 32'hFFFF_0000, 3, 0, 1, STATUS_OK));
    directed.push_back(row(KIND_TICK, 0, 0, 0, 0, 0, STATUS_OK));
    directed.push_back(row(KIND_CLEAR, 0, 0, 0, 0, 1, STATUS_OK));

    foreach (directed[i]) begin
      send_item(directed[i].it);
      if (directed[i].known && expected_q[$] != directed[i].res)
        report_mismatch($sformatf("directed row %0d prediction", i));
    end

    // full table with pressure: receiver holds off while ticks queue up
    for (int i = 0; i < 16; i++) begin
      it = '{kind: KIND_POST_PERIODIC, task_id: 8'(40 + i), context_req: $urandom,
             delay: 0, period: 0};
      send_item(it);
    end
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (4) send_item('{kind: KIND_TICK, task_id: 0, context_req: 0, delay: 0,
                             period: 0});
    join
    send_item('{kind: KIND_CLEAR, task_id: 0, context_req: 0, delay: 0, period: 0});

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        3: begin send_idle_pct = 18; stall_pct = 18; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      repeat (80) send_item(rand_item());
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("** one_shot_periodic_timer_table: PASSED **");
    else $display("** one_shot_periodic_timer_table: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ospt_pkg.sv
hw/rtl/ospt_ctrl.sv
hw/rtl/ospt_dp.sv
hw/rtl/one_shot_periodic_timer_table.sv
hw/rtl/ospt_checker.sv
tb/tb_top.sv
